// ===== src/sst_pkg.sv =====
// Shared types, character codes and lookup functions for the scenario script tokenizer.
package sst_pkg;

  localparam int unsigned WIN_DEPTH = 9;
  localparam int unsigned MAX_RES   = 9;
  localparam int unsigned CNT_W     = $clog2(MAX_RES + 1);
  localparam int unsigned FILL_W    = $clog2(WIN_DEPTH + 1);

  localparam logic [7:0] CH_LBRACK = 8'h5B;  // '['
  localparam logic [7:0] CH_RBRACK = 8'h5D;  // ']'
  localparam logic [7:0] CH_SEMI   = 8'h3B;  // ';'
  localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
  localparam logic [7:0] CH_LF     = 8'h0A;  // newline

  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_TAG   = 2'd1;
  localparam logic [1:0] KIND_LABEL = 2'd2;

  localparam logic [3:0] SKIP_NAME_LEN = 4'd7;
  localparam logic [3:0] TAG_LEN_MAX   = 4'd15;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] node_kind;
    logic       node_start;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]           cnt;
    out_item_t [MAX_RES-1:0]    res;
  } sst_burst_t;

  // "iscript"
  function automatic logic [7:0] skip_name_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h69;
      3'd1:    ch = 8'h73;
      3'd2:    ch = 8'h63;
      3'd3:    ch = 8'h72;
      3'd4:    ch = 8'h69;
      3'd5:    ch = 8'h70;
      3'd6:    ch = 8'h74;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "endscrip"
  function automatic logic [7:0] end_mark_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h65;
      3'd1:    ch = 8'h6E;
      3'd2:    ch = 8'h64;
      3'd3:    ch = 8'h73;
      3'd4:    ch = 8'h63;
      3'd5:    ch = 8'h72;
      3'd6:    ch = 8'h69;
      default: ch = 8'h70;
    endcase
    return ch;
  endfunction

endpackage

// ===== src/sst_lexer.sv =====
// Lexer state and per-byte decode: turns one script byte into a burst of tagged results.
module sst_lexer import sst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  in_item_t   item_i,
  output sst_burst_t burst_o
);

  typedef enum logic [2:0] {
    MODE_TEXT,
    MODE_TAG,
    MODE_COMMENT,
    MODE_LABEL,
    MODE_SKIP
  } mode_e;

  mode_e             mode_q, mode_d;
  logic              als_q, als_d;
  logic [7:0]        win_q [WIN_DEPTH];
  logic [7:0]        win_d [WIN_DEPTH];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [3:0]        len_q, len_d;
  logic              match_q, match_d;
  logic              begun_q, begun_d;

  always_comb begin
    logic [7:0] c;
    logic       full;
    logic       hit;
    logic [7:0] x;
    logic       has_head;
    logic       has_tail;
    logic       head_start;
    logic       tail_start;
    logic [1:0] tail_kind;

    c          = item_i.in_byte;
    mode_d     = mode_q;
    als_d      = als_q;
    win_d      = win_q;
    fill_d     = fill_q;
    len_d      = len_q;
    match_d    = match_q;
    begun_d    = begun_q;
    burst_o    = '0;
    full       = 1'b0;
    hit        = 1'b0;
    x          = 8'h00;
    has_head   = 1'b0;
    has_tail   = 1'b0;
    head_start = 1'b0;
    tail_start = 1'b0;
    tail_kind  = KIND_TEXT;

    if (mode_q == MODE_SKIP) begin
      // slide the window when full, otherwise append at the fill point
      full = (fill_q == FILL_W'(WIN_DEPTH));
      if (full) begin
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[WIN_DEPTH-1] = c;
        fill_d = FILL_W'(WIN_DEPTH);
      end else begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
          if (fill_q == FILL_W'(i)) begin
            win_d[i] = c;
          end
        end
        fill_d = fill_q + FILL_W'(1);
      end

      hit = (fill_d == FILL_W'(WIN_DEPTH));
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        if (win_d[i+1] != end_mark_char(3'(i))) begin
          hit = 1'b0;
        end
      end

      if (hit) begin
        // replay the window as text: oldest byte decides the node, then the end mark
        fill_d = '0;
        x      = win_d[0];
        if (x == CH_LBRACK) begin
          mode_d     = MODE_TAG;
          has_tail   = 1'b1;
          tail_kind  = KIND_TAG;
          tail_start = 1'b1;
          len_d      = 4'd8;
          match_d    = 1'b0;
          begun_d    = 1'b1;
        end else if (als_q && x == CH_SEMI) begin
          mode_d  = MODE_COMMENT;
          begun_d = 1'b0;
        end else if (als_q && x == CH_STAR) begin
          mode_d     = MODE_LABEL;
          has_tail   = 1'b1;
          tail_kind  = KIND_LABEL;
          tail_start = 1'b1;
          begun_d    = 1'b1;
        end else begin
          mode_d     = MODE_TEXT;
          has_head   = (x != CH_LF);
          head_start = !begun_q;
          has_tail   = 1'b1;
          tail_kind  = KIND_TEXT;
          tail_start = !has_head && !begun_q;
          als_d      = 1'b0;
          begun_d    = 1'b1;
        end

        for (int i = 0; i < MAX_RES; i++) begin
          if (has_head) begin
            if (i == 0) begin
              burst_o.res[i] = '{out_byte: x, node_kind: KIND_TEXT,
                                 node_start: head_start, run_last: 1'b0};
            end else begin
              burst_o.res[i] = '{out_byte: end_mark_char(3'(i - 1)), node_kind: tail_kind,
                                 node_start: 1'b0, run_last: 1'b0};
            end
          end else if (i < MAX_RES - 1) begin
            burst_o.res[i] = '{out_byte: end_mark_char(3'(i)), node_kind: tail_kind,
                               node_start: (i == 0) ? tail_start : 1'b0, run_last: 1'b0};
          end
        end
        if (has_tail) begin
          burst_o.cnt = has_head ? CNT_W'(MAX_RES) : CNT_W'(MAX_RES - 1);
        end
      end
    end else begin
      unique case (mode_q)
        MODE_TEXT: begin
          if (c == CH_LBRACK) begin
            mode_d  = MODE_TAG;
            begun_d = 1'b0;
            len_d   = '0;
            match_d = 1'b1;
          end else if (als_q && c == CH_SEMI) begin
            mode_d  = MODE_COMMENT;
            begun_d = 1'b0;
          end else if (als_q && c == CH_STAR) begin
            mode_d  = MODE_LABEL;
            begun_d = 1'b0;
          end else begin
            if (c != CH_LF) begin
              burst_o.cnt    = CNT_W'(1);
              burst_o.res[0] = '{out_byte: c, node_kind: KIND_TEXT,
                                 node_start: !begun_q, run_last: 1'b0};
              begun_d        = 1'b1;
            end
            als_d = (c == CH_LF);
          end
        end
        MODE_TAG: begin
          if (c == CH_RBRACK) begin
            mode_d  = (match_q && len_q == SKIP_NAME_LEN) ? MODE_SKIP : MODE_TEXT;
            begun_d = 1'b0;
            fill_d  = '0;
          end else begin
            if (len_q >= SKIP_NAME_LEN || c != skip_name_char(len_q[2:0])) begin
              match_d = 1'b0;
            end
            if (len_q < TAG_LEN_MAX) begin
              len_d = len_q + 4'd1;
            end
            burst_o.cnt    = CNT_W'(1);
            burst_o.res[0] = '{out_byte: c, node_kind: KIND_TAG,
                               node_start: !begun_q, run_last: 1'b0};
            begun_d        = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (c == CH_LF) begin
            mode_d  = MODE_TEXT;
            begun_d = 1'b0;
          end
        end
        MODE_LABEL: begin
          if (c == CH_LF) begin
            mode_d  = MODE_TEXT;
            begun_d = 1'b0;
          end else begin
            burst_o.cnt    = CNT_W'(1);
            burst_o.res[0] = '{out_byte: c, node_kind: KIND_LABEL,
                               node_start: !begun_q, run_last: 1'b0};
            begun_d        = 1'b1;
          end
        end
        default: begin
          mode_d = MODE_TEXT;
        end
      endcase
    end

    // end of script: start the next one from a clean state
    if (item_i.in_last) begin
      mode_d  = MODE_TEXT;
      als_d   = 1'b1;
      fill_d  = '0;
      len_d   = '0;
      match_d = 1'b1;
      begun_d = 1'b0;
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_d[i] = 8'h00;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_TEXT;
      als_q   <= 1'b1;
      fill_q  <= '0;
      len_q   <= '0;
      match_q <= 1'b1;
      begun_q <= 1'b0;
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_q[i] <= 8'h00;
      end
    end else if (step_i) begin
      mode_q  <= mode_d;
      als_q   <= als_d;
      fill_q  <= fill_d;
      len_q   <= len_d;
      match_q <= match_d;
      begun_q <= begun_d;
      win_q   <= win_d;
    end
  end

endmodule

// ===== src/scenario_script_tokenizer.sv =====
// Scenario script tokenizer top level: input register, lexer and result burst drain.
//
// Usage: script bytes enter on the in channel (in_valid_i/in_ready_o, payload
// in_data_i with in_byte and in_last); tagged content bytes leave on the out
// channel (out_valid_o/out_ready_i, payload out_data_o). Each input byte yields
// zero or one result, except the byte that completes the end mark of a skip
// region, which yields up to nine results (the replayed window).
// Path: a transferred byte is held in the input register, then decoded by the
// lexer into the burst register, from which its results transfer.
// Throughput: one byte per cycle while each byte yields at most one result and
// the receiver is ready; a nine-result burst holds the input until the single
// output port has drained the burst register, one result per cycle while out_ready_i is high.
// A new byte is taken while the last result of the previous burst transfers.
// Bytes that yield no result pass through and show nothing.
// Reset puts the lexer in text mode at line start with an empty window.
// When the receiver stalls, the burst register holds and the input register
// fills, after which in_ready_o drops until results drain.
module scenario_script_tokenizer import sst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic             in_vld_q;
  in_item_t         in_q;
  sst_burst_t       burst_q;
  sst_burst_t       burst;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] pos_q;
  logic             busy;
  logic             take;
  logic             final_take;
  logic             step;

  assign busy       = (cnt_q != '0);
  assign take       = busy && out_ready_i;
  assign final_take = take && ((pos_q + CNT_W'(1)) == cnt_q);
  assign step       = in_vld_q && (!busy || final_take);
  assign in_ready_o = !in_vld_q || step;

  sst_lexer u_lexer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (in_q),
    .burst_o (burst)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      cnt_q    <= '0;
      pos_q    <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (step) begin
        cnt_q <= burst.cnt;
        pos_q <= '0;
      end else if (final_take) begin
        cnt_q <= '0;
        pos_q <= '0;
      end else if (take) begin
        pos_q <= pos_q + CNT_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (step) begin
      burst_q <= burst;
    end
  end

  always_comb begin
    out_data_o          = burst_q.res[pos_q];
    out_data_o.run_last = ((pos_q + CNT_W'(1)) == cnt_q);
  end

  assign out_valid_o = busy;

endmodule

// ===== test/tb_scenario_script_tokenizer.sv =====
// Self-checking testbench for the scenario script tokenizer: byte stimulus, lexer predictor.
`timescale 1ns / 100ps

module tb_scenario_script_tokenizer;
  import sst_pkg::*;

  typedef enum logic [2:0] {
    LX_TEXT,
    LX_TAG,
    LX_COMMENT,
    LX_LABEL,
    LX_SKIP
  } lex_mode_e;

  localparam logic [8*7-1:0] SKIP_WORD  = "iscript";
  localparam logic [8*8-1:0] END_WORD   = "endscrip";
  localparam int             N_ITEMS    = 450;
  localparam int             CALM_ITEMS = 60;
  localparam int             PAUSE_AT   = 250;
  localparam int             HOLD_AT    = 60;
  localparam int             HOLD_LEN   = 120;
  localparam int             DRAIN      = 20;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  in_item_t  in_data = '0;
  logic      in_ready;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  scenario_script_tokenizer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // lexer state of the predictor
  lex_mode_e  lx_mode;
  logic       lx_bol;
  logic [7:0] lx_win [WIN_DEPTH];
  int         lx_fill;
  logic [3:0] lx_tag_len;
  logic       lx_tag_ok;
  logic       lx_begun;

  out_item_t  step_tokens[$];
  out_item_t  expected_tokens[$];
  in_item_t   script_q[$];

  int         errors = 0;
  int         exp_total = 0;
  int         rx_count = 0;
  int         n_sent = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         hold_left = 0;
  logic       hold_done = 1'b0;
  logic       pausing = 1'b0;
  logic       calm = 1'b0;
  logic       feed_done = 1'b0;
  out_item_t  want_tok;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void reset_lexer();
    lx_mode    = LX_TEXT;
    lx_bol     = 1'b1;
    foreach (lx_win[i]) lx_win[i] = 8'h00;
    lx_fill    = 0;
    lx_tag_len = 4'd0;
    lx_tag_ok  = 1'b1;
    lx_begun   = 1'b0;
  endfunction

  function automatic void emit_content(input logic [7:0] c, input logic [1:0] kind);
    out_item_t tok;
    if (step_tokens.size() >= MAX_RES) return;
    tok.out_byte   = c;
    tok.node_kind  = kind;
    tok.node_start = !lx_begun;
    tok.run_last   = 1'b0;
    lx_begun = 1'b1;
    step_tokens.push_back(tok);
  endfunction

  function automatic void win_push(input logic [7:0] c);
    if (lx_fill >= WIN_DEPTH) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) lx_win[i] = lx_win[i+1];
      lx_fill = WIN_DEPTH - 1;
    end
    lx_win[lx_fill] = c;
    lx_fill++;
  endfunction

  function automatic void lex_byte(input logic [7:0] c);
    case (lx_mode)
      LX_TEXT: begin
        if (c == CH_LBRACK) begin
          lx_mode    = LX_TAG;
          lx_begun   = 1'b0;
          lx_tag_len = 4'd0;
          lx_tag_ok  = 1'b1;
        end else if (lx_bol && c == CH_SEMI) begin
          lx_mode  = LX_COMMENT;
          lx_begun = 1'b0;
        end else if (lx_bol && c == CH_STAR) begin
          lx_mode  = LX_LABEL;
          lx_begun = 1'b0;
        end else begin
          if (c != CH_LF) emit_content(c, KIND_TEXT);
          lx_bol = (c == CH_LF);
        end
      end
      LX_TAG: begin
        if (c == CH_RBRACK) begin
          lx_mode  = (lx_tag_ok && lx_tag_len == SKIP_NAME_LEN) ? LX_SKIP : LX_TEXT;
          lx_begun = 1'b0;
          lx_fill  = 0;
        end else begin
          if (lx_tag_len >= SKIP_NAME_LEN ||
              c != SKIP_WORD[8*(6-lx_tag_len[2:0]) +: 8])
            lx_tag_ok = 1'b0;
          if (lx_tag_len < TAG_LEN_MAX) lx_tag_len++;
          emit_content(c, KIND_TAG);
        end
      end
      LX_COMMENT: begin
        if (c == CH_LF) begin
          lx_mode  = LX_TEXT;
          lx_begun = 1'b0;
        end
      end
      LX_LABEL: begin
        if (c == CH_LF) begin
          lx_mode  = LX_TEXT;
          lx_begun = 1'b0;
        end else begin
          emit_content(c, KIND_LABEL);
        end
      end
      default: win_push(c);
    endcase
  endfunction

  // Returns the number of tokens the byte produces and queues them as expected.
  function automatic int tokenize_byte(input in_item_t item);
    logic [7:0] replay [WIN_DEPTH];
    int         n;
    step_tokens.delete();
    if (lx_mode == LX_SKIP) begin
      win_push(item.in_byte);
      if (lx_fill == WIN_DEPTH &&
          {lx_win[1], lx_win[2], lx_win[3], lx_win[4],
           lx_win[5], lx_win[6], lx_win[7], lx_win[8]} == END_WORD) begin
        // re-lex the whole window as text, oldest byte first
        replay  = lx_win;
        lx_fill = 0;
        lx_mode = LX_TEXT;
        for (int i = 0; i < WIN_DEPTH; i++) lex_byte(replay[i]);
      end
    end else begin
      lex_byte(item.in_byte);
    end
    n = step_tokens.size();
    if (n > 0) step_tokens[n-1].run_last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    if (item.in_last) reset_lexer();
    return n;
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic last);
    in_item_t it;
    it.in_byte = b;
    it.in_last = last;
    script_q.push_back(it);
  endtask

  task automatic add_text(input string s);
    foreach (s[i]) add_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_plain();
    if ($urandom_range(0, 7) == 0) return 8'h20;
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  // script builder
  initial begin
    string      junk_set;
    int         len;
    logic [7:0] b;
    reset_lexer();
    junk_set = "endscripxz";

    // directed: stray ';', comment, label, newline in a tag, empty tag,
    // extreme byte values, end of script, skip left open at end of script
    add_text("x;\n;c\n*L\n[\n][]");
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_text("[iscript]");
    add_byte("q", 1'b1);

    // directed: skip ends whose oldest window byte opens a label, a comment,
    // a tag, or is a newline
    add_text("\n[iscript]*endscript\n");
    add_text("[iscript];endscript\n");
    add_text("[iscript][endscript]");
    add_text("[iscript]\nendscript");

    while (script_q.size() < N_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          len = $urandom_range(1, 8);
          repeat (len) add_byte(rand_plain(), 1'b0);
          if ($urandom_range(0, 1) == 1) add_byte(CH_LF, 1'b0);
        end
        2: begin
          add_byte(CH_LF, 1'b0);
          add_byte(CH_SEMI, 1'b0);
          len = $urandom_range(0, 6);
          repeat (len) begin
            b = 8'($urandom_range(0, 255));
            add_byte((b == CH_LF) ? 8'h00 : b, 1'b0);
          end
          add_byte(CH_LF, 1'b0);
        end
        3: begin
          add_byte(CH_LF, 1'b0);
          add_byte(CH_STAR, 1'b0);
          len = $urandom_range(0, 6);
          repeat (len) add_byte(rand_plain(), 1'b0);
          add_byte(CH_LF, 1'b0);
        end
        4, 5: begin
          add_byte(CH_LBRACK, 1'b0);
          case ($urandom_range(0, 3))
            0: add_text("iscr");
            1: add_text("iscripts");
            2: add_text("iscripx");
            default: begin
              len = $urandom_range(0, 17);
              repeat (len)
                add_byte(($urandom_range(0, 9) == 0) ? CH_LF : rand_plain(), 1'b0);
            end
          endcase
          add_byte(CH_RBRACK, 1'b0);
        end
        6, 7: begin
          add_text("[iscript]");
          len = $urandom_range(0, 14);
          repeat (len) begin
            if ($urandom_range(0, 3) == 0) add_byte(8'($urandom_range(0, 255)), 1'b0);
            else add_byte(junk_set[$urandom_range(0, 9)], 1'b0);
          end
          if ($urandom_range(0, 6) != 0) add_text("endscript");
        end
        8: begin
          len = $urandom_range(1, 4);
          repeat (len) add_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        default: add_byte(rand_plain(), 1'b1);
      endcase
    end
  end

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    int n_new;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      calm      <= 1'b0;
      exp_total <= 0;
      feed_done <= 1'b0;
    end else begin
      n_new = 0;
      if (in_valid && in_ready) begin
        n_new = tokenize_byte(in_data);
        n_sent++;
        if (n_sent == PAUSE_AT) pausing = 1'b1;
      end
      if (in_valid && !in_ready) begin
        // hold the current transfer
      end else if (pausing) begin
        in_valid <= 1'b0;
        if (!in_valid && rx_count >= exp_total) pausing = 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (script_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= script_q.pop_front();
        if (script_q.size() >= CALM_ITEMS && hold_left == 0 && $urandom_range(0, 9) == 0)
          gap_left = $urandom_range(1, 5);
      end else begin
        in_valid  <= 1'b0;
        feed_done <= 1'b1;
      end
      exp_total <= exp_total + n_new;
      calm      <= (script_q.size() < CALM_ITEMS);
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && rx_count >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      rx_count  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        rx_count <= rx_count + 1;
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected token byte=%h kind=%0d start=%b last=%b", $time,
                   out_data.out_byte, out_data.node_kind, out_data.node_start,
                   out_data.run_last);
          errors++;
        end else begin
          want_tok = expected_tokens.pop_front();
          if (want_tok !== out_data) begin
            $display({"%0t: expected byte=%h kind=%0d start=%b last=%b, ",
                      "got byte=%h kind=%0d start=%b last=%b"},
                     $time, want_tok.out_byte, want_tok.node_kind, want_tok.node_start,
                     want_tok.run_last, out_data.out_byte, out_data.node_kind,
                     out_data.node_start, out_data.run_last);
            errors++;
          end
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (!(feed_done && rx_count >= exp_total)) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (expected_tokens.size() != 0) begin
      $display("%0t: %0d expected tokens never arrived, next byte=%h kind=%0d",
               $time, expected_tokens.size(), expected_tokens[0].out_byte,
               expected_tokens[0].node_kind);
      errors++;
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
